// ===== src/smta_pkg.sv =====
// Types and constants shared by the sparse matrix triplet adder.
`timescale 1ns / 1ps

package smta_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned COORD_W = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DATA_W  = 2 * COORD_W + VALUE_W;
  localparam int unsigned OUSER_W = 2;

  // Item kinds carried on in_tuser
  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MERGE       = 2'd2;

  // Saturation limits of a result value
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_FINISH
  } smta_state_t;

endpackage

// ===== src/sparse_matrix_triplet_add_core.sv =====
// Sparse matrix adder: loads two sorted triplet lists and streams out their merged sum.
`timescale 1ns / 1ps

// Items on the input stream either append a (row, column, value) term to one of two
// lists held in single-port synchronous memories of LIST_DEPTH entries, or start a
// merge. A load into a full list is dropped and raises the overflow flag reported on
// every result of the next run. A merge walks both lists head to head: each step is a
// memory read state followed by a compare and add state, and a step waits while a
// pending result cannot leave. Equal positions add with 32-bit saturation and a zero
// sum is left out; one result is held back so the final one can carry tlast, and an
// empty result gives a single marker item. Both lists and the flag clear when the run
// ends. No new item is taken while a merge runs; loads resume while the last result
// waits.
module sparse_matrix_triplet_add_core #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // row [15:0], column [31:16], value [63:32]
  input  logic [smta_pkg::DATA_W-1:0]   in_tdata,
  // kind [1:0]
  input  logic [smta_pkg::KIND_W-1:0]   in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_row [15:0], out_column [31:16], out_value [63:32]
  output logic [smta_pkg::DATA_W-1:0]   out_tdata,
  output logic                          out_tlast,
  // no_terms [0], overflowed [1]
  output logic [smta_pkg::OUSER_W-1:0]  out_tuser
);
  import smta_pkg::*;

  localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned KEYW = 2 * COORD_BITS;
  localparam int unsigned EW  = KEYW + VALUE_W;

  // Term stores: {row, column, value}
  logic [EW-1:0] mem_a [LIST_DEPTH];
  logic [EW-1:0] mem_b [LIST_DEPTH];
  logic [EW-1:0] rd_a_r, rd_b_r;

  smta_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_b_r, i_r, j_r;
  logic          ovf_r;
  logic          pend_valid_r;
  logic [KEYW-1:0]    pend_key_r;
  logic [VALUE_W-1:0] pend_val_r;
  logic                out_valid_r, out_last_r, out_none_r, out_ovf_r;
  logic [COORD_W-1:0]  out_row_r, out_col_r;
  logic [VALUE_W-1:0]  out_val_r;

  logic in_fire, out_free;
  logic [KIND_W-1:0]  in_kind;
  logic [EW-1:0]      in_term;
  logic a_has, b_has, take_a, take_b, cand_emit, step_go;
  logic push_pend, fin_load, load_a, load_b, merge_start;
  logic [KEYW-1:0]    ka, kb, cand_key;
  logic [VALUE_W-1:0] va, vb, sum_sat, cand_val;
  logic [VALUE_W:0]   sum_w;

  assign in_kind = in_tuser;
  assign in_term = {in_tdata[COORD_BITS-1:0], in_tdata[COORD_W +: COORD_BITS],
                    in_tdata[2*COORD_W +: VALUE_W]};
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Head compare and saturating add
  assign a_has = i_r < cnt_a_r;
  assign b_has = j_r < cnt_b_r;
  assign ka = rd_a_r[EW-1 -: KEYW];
  assign kb = rd_b_r[EW-1 -: KEYW];
  assign va = rd_a_r[VALUE_W-1:0];
  assign vb = rd_b_r[VALUE_W-1:0];
  assign take_a = !b_has || (a_has && (ka < kb));
  assign take_b = !take_a && (!a_has || (ka > kb));
  assign sum_w  = {va[VALUE_W-1], va} + {vb[VALUE_W-1], vb};

  always_comb begin
    if (sum_w[VALUE_W] != sum_w[VALUE_W-1]) begin
      sum_sat = sum_w[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      sum_sat = sum_w[VALUE_W-1:0];
    end
  end

  always_comb begin
    priority if (take_a) begin
      cand_key  = ka;
      cand_val  = va;
      cand_emit = 1'b1;
    end else if (take_b) begin
      cand_key  = kb;
      cand_val  = vb;
      cand_emit = 1'b1;
    end else begin
      cand_key  = ka;
      cand_val  = sum_sat;
      cand_emit = (sum_sat != '0);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_kind == KIND_MERGE) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = (a_has || b_has) ? ST_MERGE : ST_FINISH;
      end
      ST_MERGE: begin
        if (step_go) state_nxt = ST_READ;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    step_go     = 1'b0;
    push_pend   = 1'b0;
    fin_load    = 1'b0;
    load_a      = 1'b0;
    load_b      = 1'b0;
    merge_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_LOAD_FIRST:  load_a      = 1'b1;
            KIND_LOAD_SECOND: load_b      = 1'b1;
            KIND_MERGE:       merge_start = 1'b1;
            default:          ;
          endcase
        end
      end
      ST_MERGE: begin
        // hold the step while a pending result cannot leave
        step_go   = !cand_emit || !pend_valid_r || out_free;
        push_pend = cand_emit && pend_valid_r && out_free;
      end
      ST_FINISH: begin
        fin_load = out_free;
      end
      default: ;
    endcase
  end

  // Memories: one write or one read per cycle each
  always_ff @(posedge clk) begin
    if (load_a && cnt_a_r < CW'(LIST_DEPTH)) mem_a[cnt_a_r[AW-1:0]] <= in_term;
    else rd_a_r <= mem_a[i_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_b && cnt_b_r < CW'(LIST_DEPTH)) mem_b[cnt_b_r[AW-1:0]] <= in_term;
    else rd_b_r <= mem_b[j_r[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_a) begin
        if (cnt_a_r < CW'(LIST_DEPTH)) cnt_a_r <= cnt_a_r + 1'b1;
        else                           ovf_r   <= 1'b1;
      end
      if (load_b) begin
        if (cnt_b_r < CW'(LIST_DEPTH)) cnt_b_r <= cnt_b_r + 1'b1;
        else                           ovf_r   <= 1'b1;
      end
      if (merge_start) begin
        i_r          <= '0;
        j_r          <= '0;
        pend_valid_r <= 1'b0;
      end
      if (state_r == ST_MERGE && step_go) begin
        if (!take_b) i_r <= i_r + 1'b1;
        if (!take_a) j_r <= j_r + 1'b1;
        if (cand_emit) pend_valid_r <= 1'b1;
      end
      if (fin_load) begin
        cnt_a_r      <= '0;
        cnt_b_r      <= '0;
        ovf_r        <= 1'b0;
        pend_valid_r <= 1'b0;
      end
      if (out_free) out_valid_r <= push_pend || fin_load;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_MERGE && step_go && cand_emit) begin
      pend_key_r <= cand_key;
      pend_val_r <= cand_val;
    end
    if (push_pend || fin_load) begin
      out_ovf_r <= ovf_r;
      if (push_pend || pend_valid_r) begin
        out_row_r  <= COORD_W'(pend_key_r[KEYW-1 -: COORD_BITS]);
        out_col_r  <= COORD_W'(pend_key_r[COORD_BITS-1:0]);
        out_val_r  <= pend_val_r;
        out_none_r <= 1'b0;
      end else begin
        // empty result: send the marker
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_val_r  <= '0;
        out_none_r <= 1'b1;
      end
      out_last_r <= fin_load;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_none_r};

endmodule
